// ===== src/arcdir_pkg.sv =====
// Package for the block cache directory: default sizes, field widths,
// list and tag codes, outcome codes and sequencer state types.
// No dependencies; used by the top level by scoped names.
package arcdir_pkg;

   localparam int unsigned MAX_BLOCKS_DEF   = 256;
   localparam int unsigned DIR_DEPTH_DEF    = 512;
   localparam int unsigned BLOCK_SHIFT_DEF  = 12;
   localparam int unsigned ID_BITS_DEF      = 32;
   localparam int unsigned OFFSET_BITS_DEF  = 48;

   localparam int unsigned CAP_BITS         = 9;
   localparam int unsigned CAP_RESET        = 256;
   localparam int unsigned FIELD_ID_BITS    = 32;
   localparam int unsigned FIELD_OFF_BITS   = 48;
   localparam int unsigned OUTCOME_BITS     = 3;
   localparam int unsigned TAG_BITS         = 3;

   localparam logic [1:0] L_T1 = 2'd0;
   localparam logic [1:0] L_T2 = 2'd1;
   localparam logic [1:0] L_B1 = 2'd2;
   localparam logic [1:0] L_B2 = 2'd3;

   localparam logic [TAG_BITS-1:0] TAG_FREE = 3'd0;
   localparam logic [TAG_BITS-1:0] TAG_T1   = 3'd1;
   localparam logic [TAG_BITS-1:0] TAG_T2   = 3'd2;
   localparam logic [TAG_BITS-1:0] TAG_B1   = 3'd3;
   localparam logic [TAG_BITS-1:0] TAG_B2   = 3'd4;

   localparam logic [OUTCOME_BITS-1:0] OUT_MISS = 3'd4;

   typedef enum logic [11:0] {
      ST_CLEAR    = 12'b000000000001,
      ST_IDLE     = 12'b000000000010,
      ST_SCAN     = 12'b000000000100,
      ST_DECIDE   = 12'b000000001000,
      ST_DIV      = 12'b000000010000,
      ST_ADAPT    = 12'b000000100000,
      ST_DISPATCH = 12'b000001000000,
      ST_MV_RD    = 12'b000010000000,
      ST_MV_UL    = 12'b000100000000,
      ST_PU_A     = 12'b001000000000,
      ST_PU_B     = 12'b010000000000,
      ST_RESP     = 12'b100000000000
   } state_type;

   typedef enum logic [5:0] {
      PH_ADJ    = 6'b000001,
      PH_REPL_M = 6'b000010,
      PH_REPL_G = 6'b000100,
      PH_FOUND  = 6'b001000,
      PH_INSERT = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

endpackage

// ===== src/arcdir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arcdir_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/arcdir_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ghost-hit step size.
// No dependencies.
module arcdir_div #(
   parameter int unsigned W = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int unsigned NW = $clog2(W + 1);

   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = NW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/arc_block_cache_directory_top.sv =====
// Adaptive replacement cache directory for file blocks: scan, list update
// and eviction sequencer. Uses arcdir_pkg, arcdir_ram and arcdir_div.
//
// Usage:
//   req_* takes one item: a file id and a byte offset. rsp_* returns one item
//   per request: outcome, aligned offset, fetch flag, the evicted block if any
//   and the adaptive target after the request. csr_* writes the capacity in
//   blocks; a write empties the directory and sets the target to half.
// Sequencing:
//   One item at a time. A request scans the directory one entry per cycle
//   through the tag/key RAM read port and stops at the first match; a miss
//   scans the whole directory. The list moves then run on the link RAMs, at
//   most three moves per item, and a ghost hit also runs the serial divider.
// Reset and configuration:
//   Reset, and every capacity write, run a tag clearing pass over all
//   DIRECTORY_DEPTH entries; req_tready stays low meanwhile. csr_ready is
//   always high.
// Stall:
//   The result sits in an output register; the block takes the next request
//   while it waits, and holds a finished result until the register is free.
module arc_block_cache_directory_top #(
   parameter int unsigned MAX_BLOCKS      = arcdir_pkg::MAX_BLOCKS_DEF,
   parameter int unsigned DIRECTORY_DEPTH = arcdir_pkg::DIR_DEPTH_DEF,
   parameter int unsigned BLOCK_SHIFT     = arcdir_pkg::BLOCK_SHIFT_DEF,
   parameter int unsigned ID_BITS         = arcdir_pkg::ID_BITS_DEF,
   parameter int unsigned OFFSET_BITS     = arcdir_pkg::OFFSET_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // file_id[31:0], byte_offset[79:32]
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // outcome[2:0], block_offset[50:3], fetch_needed[51], evict_valid[52],
   // evict_file_id[84:53], evict_offset[132:85], target_recent[141:133]
   output logic [143:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [8:0]   csr_wdata
);

   localparam int unsigned AW      = $clog2(DIRECTORY_DEPTH);
   localparam int unsigned PTRW    = AW + 1;
   localparam int unsigned BW      = OFFSET_BITS - BLOCK_SHIFT;
   localparam int unsigned KW      = ID_BITS + BW;
   localparam int unsigned CW      = $clog2(2 * MAX_BLOCKS + 1);
   localparam int unsigned PW      = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned TW      = arcdir_pkg::TAG_BITS;
   localparam int unsigned CAP_MAX = (MAX_BLOCKS < DIRECTORY_DEPTH / 2) ?
                                     MAX_BLOCKS : DIRECTORY_DEPTH / 2;
   localparam int unsigned CAP_RST = (arcdir_pkg::CAP_RESET < CAP_MAX) ?
                                     arcdir_pkg::CAP_RESET : CAP_MAX;
   localparam logic [PTRW-1:0] NIL = PTRW'(DIRECTORY_DEPTH);

   arcdir_pkg::state_type state_ff, state_in;
   arcdir_pkg::phase_type phase_ff, phase_in;

   logic [PTRW-1:0] scan_idx_ff, scan_idx_in;
   logic            scan_vld_ff, scan_vld_in;
   logic [AW-1:0]   scan_prev_ff, scan_prev_in;
   logic            hit_ff, hit_in;
   logic [AW-1:0]   found_ff, found_in;
   logic [TW-1:0]   ftag_ff, ftag_in;
   logic [PTRW-1:0] free_ff, free_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [BW-1:0]   blk_ff, blk_in;
   logic [AW-1:0]   clr_ff, clr_in;

   logic [AW-1:0]   op_e_ff, op_e_in;
   logic [1:0]      op_src_ff, op_src_in;
   logic [1:0]      op_dst_ff, op_dst_in;
   logic            op_free_ff, op_free_in;
   logic            op_ev_ff, op_ev_in;
   logic            op_ins_ff, op_ins_in;
   logic [PTRW-1:0] op_hd_ff, op_hd_in;

   logic [PTRW-1:0] heads_ff [4];
   logic [PTRW-1:0] heads_in [4];
   logic [PTRW-1:0] tails_ff [4];
   logic [PTRW-1:0] tails_in [4];
   logic [CW-1:0]   cnt_ff [4];
   logic [CW-1:0]   cnt_in [4];
   logic [PW-1:0]   cap_ff, cap_in;
   logic [PW-1:0]   p_ff, p_in;

   logic            ev_valid_ff, ev_valid_in;
   logic [ID_BITS-1:0] ev_id_ff, ev_id_in;
   logic [BW-1:0]   ev_blk_ff, ev_blk_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [143:0]    rsp_data_ff, rsp_data_in;

   logic [AW-1:0]   rd_addr;
   logic [TW-1:0]   tag_rd;
   logic [KW-1:0]   key_rd;
   logic [PTRW-1:0] prev_rd, next_rd;
   logic            tag_we, key_we, prev_we, next_we;
   logic [AW-1:0]   tag_wa, key_wa, prev_wa, next_wa;
   logic [TW-1:0]   tag_wd;
   logic [PTRW-1:0] prev_wd, next_wd;

   logic            div_start, div_done;
   logic [CW-1:0]   div_a, div_b, div_q, step_d;

   logic [PW-1:0]   cap_new;
   logic [OFFSET_BITS-1:0] req_off;

   logic            ln_go, ln_unlink, ln_free, ln_ev, ln_ins, rp_b2, rp_cond;
   logic [AW-1:0]   ln_e;
   logic [1:0]      ln_src, ln_dst, rp_prim, rp_oth;
   arcdir_pkg::phase_type ln_next;
   logic [CW:0]     l1_sum, p_sum;
   logic [CW+1:0]   all_sum, cap2;
   logic [PTRW-1:0] hd;
   logic [arcdir_pkg::OUTCOME_BITS-1:0] outcome_v;
   logic            fetch_v;

   assign req_off = OFFSET_BITS'(req_tdata[79:32]);

   always_comb begin
      if (csr_wdata == 9'd0) begin
         cap_new = PW'(1);
      end else if (32'(csr_wdata) > 32'(CAP_MAX)) begin
         cap_new = PW'(CAP_MAX);
      end else begin
         cap_new = PW'(csr_wdata);
      end
   end

   assign div_a     = (ftag_ff == arcdir_pkg::TAG_B1) ? cnt_ff[arcdir_pkg::L_B2]
                                                      : cnt_ff[arcdir_pkg::L_B1];
   assign div_b     = (ftag_ff == arcdir_pkg::TAG_B1) ? cnt_ff[arcdir_pkg::L_B1]
                                                      : cnt_ff[arcdir_pkg::L_B2];
   assign div_start = (state_ff == arcdir_pkg::ST_DECIDE) && hit_ff &&
                      ((ftag_ff == arcdir_pkg::TAG_B1) || (ftag_ff == arcdir_pkg::TAG_B2));
   assign step_d    = ((div_b == '0) || (div_q == '0)) ? CW'(1) : div_q;

   // replace choice
   always_comb begin
      rp_b2   = (phase_ff == arcdir_pkg::PH_REPL_G) && (ftag_ff == arcdir_pkg::TAG_B2);
      rp_cond = (cnt_ff[arcdir_pkg::L_T1] != '0) &&
                (((CW+1)'(cnt_ff[arcdir_pkg::L_T1]) > (CW+1)'(p_ff)) ||
                 (rp_b2 && ((CW+1)'(cnt_ff[arcdir_pkg::L_T1]) == (CW+1)'(p_ff))));
      rp_prim = rp_cond ? arcdir_pkg::L_T1 : arcdir_pkg::L_T2;
      rp_oth  = rp_cond ? arcdir_pkg::L_T2 : arcdir_pkg::L_T1;
      l1_sum  = (CW+1)'(cnt_ff[arcdir_pkg::L_T1]) + (CW+1)'(cnt_ff[arcdir_pkg::L_B1]);
      all_sum = (CW+2)'(l1_sum) + (CW+2)'(cnt_ff[arcdir_pkg::L_T2]) +
                (CW+2)'(cnt_ff[arcdir_pkg::L_B2]);
      cap2    = (CW+2)'({cap_ff, 1'b0});
   end

   // next operation of the sequencer
   always_comb begin
      ln_go     = 1'b0;
      ln_unlink = 1'b1;
      ln_free   = 1'b0;
      ln_ev     = 1'b1;
      ln_ins    = 1'b0;
      ln_e      = '0;
      ln_src    = arcdir_pkg::L_T1;
      ln_dst    = arcdir_pkg::L_T1;
      ln_next   = arcdir_pkg::PH_DONE;
      case (phase_ff)
         arcdir_pkg::PH_ADJ: begin
            ln_free = 1'b1;
            if (l1_sum >= (CW+1)'(cap_ff)) begin
               if ((CW+1)'(cnt_ff[arcdir_pkg::L_T1]) < (CW+1)'(cap_ff)) begin
                  ln_src  = arcdir_pkg::L_B1;
                  ln_next = arcdir_pkg::PH_REPL_M;
               end else begin
                  ln_src  = arcdir_pkg::L_T1;
                  ln_next = arcdir_pkg::PH_INSERT;
               end
               ln_go = tails_ff[ln_src] < NIL;
            end else if (all_sum >= (CW+2)'(cap_ff)) begin
               ln_src  = arcdir_pkg::L_B2;
               ln_next = arcdir_pkg::PH_REPL_M;
               ln_go   = (all_sum >= cap2) && (tails_ff[arcdir_pkg::L_B2] < NIL);
            end else begin
               ln_next = arcdir_pkg::PH_INSERT;
            end
            ln_e = tails_ff[ln_src][AW-1:0];
         end
         arcdir_pkg::PH_REPL_M, arcdir_pkg::PH_REPL_G: begin
            ln_next = (phase_ff == arcdir_pkg::PH_REPL_M) ? arcdir_pkg::PH_INSERT
                                                          : arcdir_pkg::PH_FOUND;
            if (tails_ff[rp_prim] < NIL) begin
               ln_src = rp_prim;
               ln_go  = 1'b1;
            end else begin
               ln_src = rp_oth;
               ln_go  = tails_ff[rp_oth] < NIL;
            end
            ln_dst = {1'b1, ln_src[0]};
            ln_e   = tails_ff[ln_src][AW-1:0];
         end
         arcdir_pkg::PH_FOUND: begin
            ln_go   = 1'b1;
            ln_ev   = 1'b0;
            ln_e    = found_ff;
            ln_src  = 2'(ftag_ff - arcdir_pkg::TAG_T1);
            ln_dst  = arcdir_pkg::L_T2;
            ln_next = arcdir_pkg::PH_DONE;
         end
         arcdir_pkg::PH_INSERT: begin
            ln_go     = free_ff < NIL;
            ln_unlink = 1'b0;
            ln_ev     = 1'b0;
            ln_ins    = 1'b1;
            ln_e      = free_ff[AW-1:0];
            ln_dst    = arcdir_pkg::L_T1;
            ln_next   = arcdir_pkg::PH_DONE;
         end
         default: begin
            ln_next = arcdir_pkg::PH_DONE;
         end
      endcase
   end

   always_comb begin
      if (!hit_ff) begin
         outcome_v = arcdir_pkg::OUT_MISS;
      end else begin
         outcome_v = arcdir_pkg::OUTCOME_BITS'(ftag_ff - arcdir_pkg::TAG_T1);
      end
      fetch_v = !hit_ff || (ftag_ff == arcdir_pkg::TAG_B1) || (ftag_ff == arcdir_pkg::TAG_B2);
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      scan_idx_in  = scan_idx_ff;
      scan_vld_in  = 1'b0;
      scan_prev_in = scan_prev_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      ftag_in      = ftag_ff;
      free_in      = free_ff;
      id_in        = id_ff;
      blk_in       = blk_ff;
      clr_in       = clr_ff;
      op_e_in      = op_e_ff;
      op_src_in    = op_src_ff;
      op_dst_in    = op_dst_ff;
      op_free_in   = op_free_ff;
      op_ev_in     = op_ev_ff;
      op_ins_in    = op_ins_ff;
      op_hd_in     = op_hd_ff;
      heads_in     = heads_ff;
      tails_in     = tails_ff;
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      p_in         = p_ff;
      ev_valid_in  = ev_valid_ff;
      ev_id_in     = ev_id_ff;
      ev_blk_in    = ev_blk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = op_e_ff;
      tag_we  = 1'b0;  tag_wa  = op_e_ff;  tag_wd  = arcdir_pkg::TAG_FREE;
      key_we  = 1'b0;  key_wa  = op_e_ff;
      prev_we = 1'b0;  prev_wa = op_e_ff;  prev_wd = NIL;
      next_we = 1'b0;  next_wa = op_e_ff;  next_wd = NIL;
      hd      = heads_ff[op_dst_ff];
      p_sum   = '0;

      case (state_ff)
         arcdir_pkg::ST_CLEAR: begin
            tag_we = 1'b1;
            tag_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DIRECTORY_DEPTH - 1)) begin
               state_in = arcdir_pkg::ST_IDLE;
            end
         end
         arcdir_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               id_in       = ID_BITS'(req_tdata[31:0]);
               blk_in      = req_off[OFFSET_BITS-1:BLOCK_SHIFT];
               scan_idx_in = '0;
               free_in     = NIL;
               hit_in      = 1'b0;
               ev_valid_in = 1'b0;
               ev_id_in    = '0;
               ev_blk_in   = '0;
               state_in    = arcdir_pkg::ST_SCAN;
            end
         end
         arcdir_pkg::ST_SCAN: begin
            rd_addr = scan_idx_ff[AW-1:0];
            if (scan_idx_ff < NIL) begin
               scan_idx_in  = scan_idx_ff + PTRW'(1);
               scan_vld_in  = 1'b1;
               scan_prev_in = scan_idx_ff[AW-1:0];
            end
            if (scan_vld_ff) begin
               if ((tag_rd != arcdir_pkg::TAG_FREE) && (key_rd == {id_ff, blk_ff})) begin
                  hit_in      = 1'b1;
                  found_in    = scan_prev_ff;
                  ftag_in     = tag_rd;
                  scan_vld_in = 1'b0;
                  state_in    = arcdir_pkg::ST_DECIDE;
               end else begin
                  if ((tag_rd == arcdir_pkg::TAG_FREE) && (free_ff == NIL)) begin
                     free_in = {1'b0, scan_prev_ff};
                  end
                  if (scan_prev_ff == AW'(DIRECTORY_DEPTH - 1)) begin
                     scan_vld_in = 1'b0;
                     state_in    = arcdir_pkg::ST_DECIDE;
                  end
               end
            end
         end
         arcdir_pkg::ST_DECIDE: begin
            if (!hit_ff) begin
               phase_in = arcdir_pkg::PH_ADJ;
               state_in = arcdir_pkg::ST_DISPATCH;
            end else if (div_start) begin
               state_in = arcdir_pkg::ST_DIV;
            end else begin
               phase_in = arcdir_pkg::PH_FOUND;
               state_in = arcdir_pkg::ST_DISPATCH;
            end
         end
         arcdir_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = arcdir_pkg::ST_ADAPT;
            end
         end
         arcdir_pkg::ST_ADAPT: begin
            if (ftag_ff == arcdir_pkg::TAG_B1) begin
               p_sum = (CW+1)'(p_ff) + (CW+1)'(step_d);
               p_in  = (p_sum > (CW+1)'(cap_ff)) ? cap_ff : PW'(p_sum);
            end else begin
               p_in  = ((CW+1)'(p_ff) > (CW+1)'(step_d)) ? PW'(p_ff - PW'(step_d)) : '0;
            end
            phase_in = arcdir_pkg::PH_REPL_G;
            state_in = arcdir_pkg::ST_DISPATCH;
         end
         arcdir_pkg::ST_DISPATCH: begin
            phase_in = ln_next;
            if (phase_ff == arcdir_pkg::PH_DONE) begin
               state_in = arcdir_pkg::ST_RESP;
            end else if (ln_go) begin
               op_e_in    = ln_e;
               op_src_in  = ln_src;
               op_dst_in  = ln_dst;
               op_free_in = ln_free;
               op_ev_in   = ln_ev;
               op_ins_in  = ln_ins;
               state_in   = ln_unlink ? arcdir_pkg::ST_MV_RD : arcdir_pkg::ST_PU_A;
            end
         end
         arcdir_pkg::ST_MV_RD: begin
            state_in = arcdir_pkg::ST_MV_UL;
         end
         arcdir_pkg::ST_MV_UL: begin
            if (prev_rd < NIL) begin
               next_we = 1'b1;
               next_wa = prev_rd[AW-1:0];
               next_wd = next_rd;
            end else begin
               heads_in[op_src_ff] = next_rd;
            end
            if (next_rd < NIL) begin
               prev_we = 1'b1;
               prev_wa = next_rd[AW-1:0];
               prev_wd = prev_rd;
            end else begin
               tails_in[op_src_ff] = prev_rd;
            end
            if (cnt_ff[op_src_ff] != '0) begin
               cnt_in[op_src_ff] = cnt_ff[op_src_ff] - CW'(1);
            end
            if (op_ev_ff && !op_src_ff[1]) begin
               ev_valid_in = 1'b1;
               ev_id_in    = key_rd[KW-1:BW];
               ev_blk_in   = key_rd[BW-1:0];
            end
            if (op_free_ff) begin
               tag_we = 1'b1;
               if ({1'b0, op_e_ff} < free_ff) begin
                  free_in = {1'b0, op_e_ff};
               end
               state_in = arcdir_pkg::ST_DISPATCH;
            end else begin
               state_in = arcdir_pkg::ST_PU_A;
            end
         end
         arcdir_pkg::ST_PU_A: begin
            next_we = 1'b1;
            next_wd = hd;
            prev_we = 1'b1;
            tag_we  = 1'b1;
            tag_wd  = TW'({1'b0, op_dst_ff}) + arcdir_pkg::TAG_T1;
            key_we  = op_ins_ff;
            heads_in[op_dst_ff] = {1'b0, op_e_ff};
            if (!(hd < NIL)) begin
               tails_in[op_dst_ff] = {1'b0, op_e_ff};
            end
            cnt_in[op_dst_ff] = cnt_ff[op_dst_ff] + CW'(1);
            op_hd_in = hd;
            state_in = (hd < NIL) ? arcdir_pkg::ST_PU_B : arcdir_pkg::ST_DISPATCH;
         end
         arcdir_pkg::ST_PU_B: begin
            prev_we  = 1'b1;
            prev_wa  = op_hd_ff[AW-1:0];
            prev_wd  = {1'b0, op_e_ff};
            state_in = arcdir_pkg::ST_DISPATCH;
         end
         arcdir_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00,
                               arcdir_pkg::CAP_BITS'(p_ff),
                               arcdir_pkg::FIELD_OFF_BITS'({ev_blk_ff,
                                                            {BLOCK_SHIFT{1'b0}}}),
                               arcdir_pkg::FIELD_ID_BITS'(ev_id_ff),
                               ev_valid_ff,
                               fetch_v,
                               arcdir_pkg::FIELD_OFF_BITS'({blk_ff, {BLOCK_SHIFT{1'b0}}}),
                               outcome_v};
               state_in     = arcdir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = arcdir_pkg::ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      if (csr_valid) begin
         cap_in   = cap_new;
         p_in     = cap_new >> 1;
         for (int i = 0; i < 4; i++) begin
            heads_in[i] = NIL;
            tails_in[i] = NIL;
            cnt_in[i]   = '0;
         end
         clr_in   = '0;
         state_in = arcdir_pkg::ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arcdir_pkg::ST_CLEAR;
         phase_ff     <= arcdir_pkg::PH_DONE;
         scan_vld_ff  <= 1'b0;
         clr_ff       <= '0;
         cap_ff       <= PW'(CAP_RST);
         p_ff         <= PW'(CAP_RST / 2);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            heads_ff[i] <= NIL;
            tails_ff[i] <= NIL;
            cnt_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         scan_vld_ff  <= scan_vld_in;
         clr_ff       <= clr_in;
         cap_ff       <= cap_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
         tails_ff     <= tails_in;
         cnt_ff       <= cnt_in;
      end
      scan_idx_ff  <= scan_idx_in;
      scan_prev_ff <= scan_prev_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      ftag_ff      <= ftag_in;
      free_ff      <= free_in;
      id_ff        <= id_in;
      blk_ff       <= blk_in;
      op_e_ff      <= op_e_in;
      op_src_ff    <= op_src_in;
      op_dst_ff    <= op_dst_in;
      op_free_ff   <= op_free_in;
      op_ev_ff     <= op_ev_in;
      op_ins_ff    <= op_ins_in;
      op_hd_ff     <= op_hd_in;
      ev_valid_ff  <= ev_valid_in;
      ev_id_ff     <= ev_id_in;
      ev_blk_ff    <= ev_blk_in;
      rsp_data_ff  <= rsp_data_in;
   end

   arcdir_ram #(.WIDTH(TW), .DEPTH(DIRECTORY_DEPTH)) u_tag_ram (
      .clock(clock), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
      .raddr(rd_addr), .rdata(tag_rd)
   );

   arcdir_ram #(.WIDTH(KW), .DEPTH(DIRECTORY_DEPTH)) u_key_ram (
      .clock(clock), .we(key_we), .waddr(key_wa), .wdata({id_ff, blk_ff}),
      .raddr(rd_addr), .rdata(key_rd)
   );

   arcdir_ram #(.WIDTH(PTRW), .DEPTH(DIRECTORY_DEPTH)) u_prev_ram (
      .clock(clock), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
      .raddr(rd_addr), .rdata(prev_rd)
   );

   arcdir_ram #(.WIDTH(PTRW), .DEPTH(DIRECTORY_DEPTH)) u_next_ram (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .raddr(rd_addr), .rdata(next_rd)
   );

   arcdir_div #(.W(CW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
   );

   assign req_tready = (state_ff == arcdir_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   a_target_le_cap: assert property (@(posedge clock) disable iff (reset)
      p_ff <= cap_ff)
      else $error("adaptive target above capacity");

   a_cached_le_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arcdir_pkg::ST_IDLE) |->
      ((CW+1)'(cnt_ff[arcdir_pkg::L_T1]) + (CW+1)'(cnt_ff[arcdir_pkg::L_T2]) <=
       (CW+1)'(cap_ff)))
      else $error("cached blocks exceed capacity");

   a_total_le_2cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arcdir_pkg::ST_IDLE) |-> (all_sum <= cap2))
      else $error("directory holds more than twice the capacity");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request taken before clearing pass");

endmodule

// ===== test/tb_arc_block_cache_directory_top.sv =====
// Testbench for arc_block_cache_directory_top: directed and random block reads
// checked item by item against an ARC directory predictor kept in the bench.
// Depends on arcdir_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_arc_block_cache_directory_top;
   import arcdir_pkg::*;

   localparam int DEPTH      = 512;
   localparam int NIL        = DEPTH;
   localparam int BSHIFT     = 12;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE     = 700;

   typedef enum logic [2:0] {
      HIT_RECENT     = 3'd0,
      HIT_FREQUENT   = 3'd1,
      GHOST_RECENT   = 3'd2,
      GHOST_FREQUENT = 3'd3,
      MISS           = 3'd4
   } outcome_e;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [47:0] block_offset;
      logic        fetch_needed;
      logic        evict_valid;
      logic [31:0] evict_file_id;
      logic [47:0] evict_offset;
      logic [8:0]  target_recent;
   } lookup_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [8:0]   csr_wdata = '0;

   arc_block_cache_directory_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // directory mirror
   logic [31:0]    dir_id   [DEPTH];
   logic [35:0]    dir_blk  [DEPTH];
   logic [2:0]     dir_tag  [DEPTH];
   int             dir_prev [DEPTH];
   int             dir_next [DEPTH];
   int             lst_head [4];
   int             lst_tail [4];
   int unsigned    lst_cnt  [4];
   logic [8:0]     target_p;
   int unsigned    capacity;
   logic           ev_hit;
   logic [31:0]    ev_id;
   logic [35:0]    ev_blk;

   lookup_t        lookup_q[$];
   int             mismatches = 0;
   int             idle_pct = 0;
   int             stall_pct = 0;
   int             hold_req = 0;
   int             hold_left = 0;
   int             quiet_cycles = 0;
   logic [31:0]    pool_id  [64];
   logic [35:0]    pool_blk [64];
   int             pool_n = 1;

   function automatic void flush_directory();
      for (int i = 0; i < DEPTH; i++) begin
         dir_tag[i]  = TAG_FREE;
         dir_prev[i] = NIL;
         dir_next[i] = NIL;
         dir_id[i]   = '0;
         dir_blk[i]  = '0;
      end
      for (int l = 0; l < 4; l++) begin
         lst_head[l] = NIL;
         lst_tail[l] = NIL;
         lst_cnt[l]  = 0;
      end
   endfunction

   function automatic void set_capacity(int unsigned v);
      flush_directory();
      capacity = (v < 1) ? 1 : (v > 256) ? 256 : v;
      target_p = 9'(capacity >> 1);
   endfunction

   function automatic void unlink(int e);
      int l, pv, nx;
      if (dir_tag[e] == TAG_FREE) return;
      l  = int'(dir_tag[e] - TAG_T1);
      pv = dir_prev[e];
      nx = dir_next[e];
      if (pv != NIL) dir_next[pv] = nx; else lst_head[l] = nx;
      if (nx != NIL) dir_prev[nx] = pv; else lst_tail[l] = pv;
      if (lst_cnt[l] > 0) lst_cnt[l]--;
      dir_tag[e]  = TAG_FREE;
      dir_prev[e] = NIL;
      dir_next[e] = NIL;
   endfunction

   function automatic void push_head(int e, int l);
      int hd;
      hd = lst_head[l];
      dir_prev[e] = NIL;
      dir_next[e] = hd;
      if (hd != NIL) dir_prev[hd] = e; else lst_tail[l] = e;
      lst_head[l] = e;
      dir_tag[e]  = TAG_T1 + 3'(l);
      lst_cnt[l]++;
   endfunction

   // dst of 4 frees the entry
   function automatic bit demote_lru(int src, int dst);
      int e;
      e = lst_tail[src];
      if (e == NIL) return 1'b0;
      unlink(e);
      if (src == int'(L_T1) || src == int'(L_T2)) begin
         ev_hit = 1'b1;
         ev_id  = dir_id[e];
         ev_blk = dir_blk[e];
      end
      if (dst < 4) push_head(e, dst);
      return 1'b1;
   endfunction

   function automatic void replace_cached(bit in_b2);
      int unsigned t1;
      t1 = lst_cnt[L_T1];
      if (t1 >= 1 && (t1 > target_p || (in_b2 && t1 == target_p))) begin
         if (!demote_lru(L_T1, L_B1)) void'(demote_lru(L_T2, L_B2));
      end else begin
         if (!demote_lru(L_T2, L_B2)) void'(demote_lru(L_T1, L_B1));
      end
   endfunction

   function automatic void make_room();
      int unsigned l1, all;
      l1  = lst_cnt[L_T1] + lst_cnt[L_B1];
      all = l1 + lst_cnt[L_T2] + lst_cnt[L_B2];
      if (l1 >= capacity) begin
         if (lst_cnt[L_T1] < capacity) begin
            void'(demote_lru(L_B1, 4));
            replace_cached(1'b0);
         end else begin
            void'(demote_lru(L_T1, 4));
         end
      end else if (all >= capacity) begin
         if (all >= 2 * capacity) void'(demote_lru(L_B2, 4));
         replace_cached(1'b0);
      end
   endfunction

   function automatic lookup_t lookup_block(logic [31:0] id, logic [47:0] off);
      lookup_t     r;
      logic [35:0] blk;
      int          found, slot;
      int unsigned b1, b2, d;
      blk   = off[47:BSHIFT];
      found = NIL;
      slot  = NIL;
      ev_hit = 1'b0;
      ev_id  = '0;
      ev_blk = '0;
      r = '0;
      r.fetch_needed = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (dir_tag[i] != TAG_FREE && dir_id[i] == id && dir_blk[i] == blk) begin
            found = i;
            break;
         end
      end
      if (found != NIL) begin
         r.outcome = dir_tag[found] - TAG_T1;
         b1 = lst_cnt[L_B1];
         b2 = lst_cnt[L_B2];
         if (dir_tag[found] == TAG_B1) begin
            d = (b1 != 0) ? b2 / b1 : 1;
            if (d < 1) d = 1;
            target_p = (target_p + d > capacity) ? 9'(capacity) : 9'(target_p + d);
            replace_cached(1'b0);
            r.fetch_needed = 1'b1;
         end else if (dir_tag[found] == TAG_B2) begin
            d = (b2 != 0) ? b1 / b2 : 1;
            if (d < 1) d = 1;
            target_p = (target_p > d) ? 9'(target_p - d) : 9'd0;
            replace_cached(1'b1);
            r.fetch_needed = 1'b1;
         end
         unlink(found);
         push_head(found, L_T2);
      end else begin
         r.outcome = MISS;
         r.fetch_needed = 1'b1;
         make_room();
         for (int i = 0; i < DEPTH; i++) begin
            if (dir_tag[i] == TAG_FREE) begin
               slot = i;
               break;
            end
         end
         if (slot != NIL) begin
            dir_id[slot]  = id;
            dir_blk[slot] = blk;
            push_head(slot, L_T1);
         end
      end
      r.block_offset  = {blk, 12'd0};
      r.evict_valid   = ev_hit;
      r.evict_file_id = ev_hit ? ev_id : 32'd0;
      r.evict_offset  = ev_hit ? {ev_blk, 12'd0} : 48'd0;
      r.target_recent = target_p;
      return r;
   endfunction

   task automatic read_block(logic [31:0] id, logic [47:0] off);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {off, id};
      do @(posedge clock); while (!req_tready);
      lookup_q.push_back(lookup_block(id, off));
   endtask

   task automatic write_capacity(logic [8:0] v);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (lookup_q.size() == 0);
      repeat (SETTLE) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      set_capacity(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic read_pool_or_noise();
      int k;
      if ($urandom_range(99) < 85) begin
         k = $urandom_range(pool_n - 1);
         read_block(pool_id[k], {pool_blk[k], 12'($urandom)});
      end else begin
         read_block($urandom, {16'($urandom), 32'($urandom)});
      end
   endtask

   task automatic fill_pool(int n);
      pool_n = n;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(3) == 0) begin
            pool_id[i]  = pool_id[i-1];
            pool_blk[i] = pool_blk[i-1] + 36'd1;
         end else begin
            pool_id[i]  = $urandom;
            pool_blk[i] = {4'($urandom), 32'($urandom)};
         end
      end
   endtask

   task automatic test_directed();
      read_block(32'd0, 48'd0);
      read_block(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      read_block(32'd0, 48'h0000_0000_0FFF);
      read_block(32'd0, 48'h0000_0000_0123);
      read_block(32'hFFFF_FFFF, 48'hFFFF_FFFF_F000);
      read_block(32'hFFFF_FFFF, 48'h0000_0000_1000);
   endtask

   // small capacity walks every list and the lower (zero) target limit
   task automatic test_ghost_paths();
      write_capacity(9'd2);
      read_block(32'hA, 48'h1000);
      read_block(32'hB, 48'h2000);
      read_block(32'hA, 48'h1000);
      read_block(32'hC, 48'h3000);
      read_block(32'hA, 48'h1000);
      read_block(32'hD, 48'h4000);
      read_block(32'hB, 48'h2000);
      read_block(32'hC, 48'h3000);
      read_block(32'hB, 48'h2000);
      read_block(32'hE, 48'h5000);
      read_block(32'hD, 48'h4000);
      write_capacity(9'd0);
      read_block(32'h1, 48'h0);
      read_block(32'h2, 48'h0);
      read_block(32'h1, 48'h0);
      read_block(32'h2, 48'h0);
      write_capacity(9'h1FF);
      read_block(32'h3, 48'h7000);
      read_block(32'h3, 48'h7000);
   endtask

   task automatic test_random_phase(int idle, int stall, logic [8:0] cap, int pool, int n);
      write_capacity(cap);
      idle_pct  = idle;
      stall_pct = stall;
      fill_pool(pool);
      repeat (n) read_pool_or_noise();
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_req  = 4000;
      repeat (10) read_pool_or_noise();
   endtask

   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic note_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected %h, got %h", name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      lookup_t exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (lookup_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", rsp_tdata);
         end else begin
            exp_r = lookup_q.pop_front();
            note_field("outcome", exp_r.outcome, rsp_tdata[2:0]);
            note_field("block_offset", exp_r.block_offset, rsp_tdata[50:3]);
            note_field("fetch_needed", exp_r.fetch_needed, rsp_tdata[51]);
            note_field("evict_valid", exp_r.evict_valid, rsp_tdata[52]);
            note_field("evict_file_id", exp_r.evict_file_id, rsp_tdata[84:53]);
            note_field("evict_offset", exp_r.evict_offset, rsp_tdata[132:85]);
            note_field("target_recent", exp_r.target_recent, rsp_tdata[141:133]);
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      set_capacity(256);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_ghost_paths();
      test_random_phase(0, 0, 9'd3, 10, 90);
      test_random_phase(50, 0, 9'd8, 24, 90);
      test_backpressure();
      test_random_phase(0, 50, 9'd1, 5, 80);
      test_random_phase(20, 20, 9'd256, 40, 90);
      test_random_phase(20, 20, 9'd5, 14, 70);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (lookup_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
